// File: rtl/geo_pkg.sv
package geo_pkg;

  localparam int LON_W  = 29;
  localparam int LAT_W  = 28;
  localparam int EDGE_W = 32;
  localparam int ZOOM_W = 16;
  localparam int CTR_W  = 15;
  localparam int TRIG_W = 17;
  localparam int PIX_W  = 32;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;

  localparam int RND_BIAS = 16383;
  localparam int Q15_SH   = 15;

  typedef enum logic [IDX_W-1:0] {
    REG_WEST   = 3'd0,
    REG_NORTH  = 3'd1,
    REG_ZOOM_X = 3'd2,
    REG_ZOOM_Y = 3'd3,
    REG_CTR_X  = 3'd4,
    REG_CTR_Y  = 3'd5,
    REG_SINE   = 3'd6,
    REG_COSINE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [LON_W-1:0] longitude;
    logic signed [LAT_W-1:0] latitude;
    logic                    batch_end;
  } in_word_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    zoom_fault;
    logic                    batch_end_out;
  } out_word_t;

  typedef struct packed {
    logic batch;
    logic neg_x;
    logic neg_y;
  } div_ctl_t;

endpackage

// File: rtl/geo_to_screen_transform.sv
// Maps one position (longitude, latitude in microdegrees) to a rotated screen pixel per
// clock. The two zoom divisions run as restoring dividers unrolled into 33 register stages
// (one quotient bit each), followed by five stages for saturation, centering, the Q15
// rotation multiplies, the rounding sums and the final shift and saturation. Throughput is
// one word per cycle, and the whole pipeline holds only while a valid output word is not
// taken. Configuration may be written only while the pipeline is empty.
module geo_to_screen_transform #(
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  geo_pkg::in_word_t                   in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output geo_pkg::out_word_t                  out_word,
  input  logic                                cfg_we,
  input  logic [geo_pkg::IDX_W-1:0]           cfg_index,
  input  logic [geo_pkg::CFG_W-1:0]           cfg_data
);
  import geo_pkg::*;

  localparam int NB   = 33;
  localparam int QW   = NB + 1;
  localparam int EXA  = (COORD_BITS > QW) ? COORD_BITS : QW;
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = DW + TRIG_W;
  localparam int SW   = PW + 2;
  localparam int RW   = SW - Q15_SH + 1;
  localparam int EXO  = (RW > PIX_W + 1) ? RW : PIX_W + 1;

  localparam logic signed [EXA-1:0] CMAX = EXA'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [EXA-1:0] CMIN = -CMAX - EXA'(1);
  localparam logic signed [EXO-1:0] PMAX = EXO'(64'sd2147483647);
  localparam logic signed [EXO-1:0] PMIN = -PMAX - EXO'(1);

  logic signed [EDGE_W-1:0] west_r, north_r;
  logic [ZOOM_W-1:0]        zx_r, zy_r;
  logic [CTR_W-1:0]         cx_r, cy_r;
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      west_r  <= '0;
      north_r <= '0;
      zx_r    <= ZOOM_W'(20);
      zy_r    <= ZOOM_W'(20);
      cx_r    <= '0;
      cy_r    <= '0;
      sin_r   <= '0;
      cos_r   <= TRIG_W'(32768);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WEST:   west_r  <= cfg_data[EDGE_W-1:0];
        REG_NORTH:  north_r <= cfg_data[EDGE_W-1:0];
        REG_ZOOM_X: zx_r    <= cfg_data[ZOOM_W-1:0];
        REG_ZOOM_Y: zy_r    <= cfg_data[ZOOM_W-1:0];
        REG_CTR_X:  cx_r    <= cfg_data[CTR_W-1:0];
        REG_CTR_Y:  cy_r    <= cfg_data[CTR_W-1:0];
        REG_SINE:   sin_r   <= cfg_data[TRIG_W-1:0];
        REG_COSINE: cos_r   <= cfg_data[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  logic fault, skip, zx_zero, adv;
  assign fault   = (zy_r == '0);
  assign zx_zero = (zx_r == '0);
  assign skip    = (sin_r == '0) && !cos_r[TRIG_W-1] && (cos_r != '0);

  logic vo_r;
  assign adv      = !vo_r || out_ready;
  assign in_ready = adv;

  logic signed [NB-1:0] diffx, diffy;
  logic [NB-1:0]        magx, magy;

  always_comb begin
    diffx = NB'(in_word.longitude) - NB'(west_r);
    diffy = NB'(north_r) - NB'(in_word.latitude);
    magx  = diffx[NB-1] ? NB'(-diffx) : NB'(diffx);
    magy  = diffy[NB-1] ? NB'(-diffy) : NB'(diffy);
  end

  logic              vd_r   [0:NB];
  div_ctl_t          ctl_r  [0:NB];
  logic [NB-1:0]     numx_r [0:NB];
  logic [NB-1:0]     numy_r [0:NB];
  logic [NB-1:0]     quox_r [0:NB];
  logic [NB-1:0]     quoy_r [0:NB];
  logic [ZOOM_W-1:0] remx_r [0:NB];
  logic [ZOOM_W-1:0] remy_r [0:NB];

  logic [NB-1:0]     numx_nxt [1:NB];
  logic [NB-1:0]     numy_nxt [1:NB];
  logic [NB-1:0]     quox_nxt [1:NB];
  logic [NB-1:0]     quoy_nxt [1:NB];
  logic [ZOOM_W-1:0] remx_nxt [1:NB];
  logic [ZOOM_W-1:0] remy_nxt [1:NB];

  always_comb begin
    logic [ZOOM_W:0] tx, ty;
    logic            gx, gy;
    for (int k = 1; k <= NB; k++) begin
      tx = {remx_r[k-1], numx_r[k-1][NB-1]};
      ty = {remy_r[k-1], numy_r[k-1][NB-1]};
      gx = (tx >= {1'b0, zx_r});
      gy = (ty >= {1'b0, zy_r});
      remx_nxt[k] = gx ? ZOOM_W'(tx - {1'b0, zx_r}) : tx[ZOOM_W-1:0];
      remy_nxt[k] = gy ? ZOOM_W'(ty - {1'b0, zy_r}) : ty[ZOOM_W-1:0];
      numx_nxt[k] = numx_r[k-1] << 1;
      numy_nxt[k] = numy_r[k-1] << 1;
      quox_nxt[k] = {quox_r[k-1][NB-2:0], gx};
      quoy_nxt[k] = {quoy_r[k-1][NB-2:0], gy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NB; k++) vd_r[k] <= 1'b0;
    end else if (adv) begin
      vd_r[0] <= in_valid;
      for (int k = 1; k <= NB; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0]  <= '{batch: in_word.batch_end, neg_x: diffx[NB-1], neg_y: diffy[NB-1]};
      numx_r[0] <= magx;
      numy_r[0] <= magy;
      quox_r[0] <= '0;
      quoy_r[0] <= '0;
      remx_r[0] <= '0;
      remy_r[0] <= '0;
      for (int k = 1; k <= NB; k++) begin
        ctl_r[k]  <= ctl_r[k-1];
        numx_r[k] <= numx_nxt[k];
        numy_r[k] <= numy_nxt[k];
        quox_r[k] <= quox_nxt[k];
        quoy_r[k] <= quoy_nxt[k];
        remx_r[k] <= remx_nxt[k];
        remy_r[k] <= remy_nxt[k];
      end
    end
  end

  logic signed [QW-1:0]         qsx, qsy;
  logic signed [EXA-1:0]        qex, qey;
  logic signed [COORD_BITS-1:0] xa_nxt, ya_nxt, xa_r, ya_r;
  logic                         va_r, ba_r;

  always_comb begin
    qsx = ctl_r[NB].neg_x ? -$signed({1'b0, quox_r[NB]}) : $signed({1'b0, quox_r[NB]});
    qsy = ctl_r[NB].neg_y ? -$signed({1'b0, quoy_r[NB]}) : $signed({1'b0, quoy_r[NB]});
    qex = EXA'(qsx);
    qey = EXA'(qsy);
    if (zx_zero)          xa_nxt = '0;
    else if (qex > CMAX)  xa_nxt = CMAX[COORD_BITS-1:0];
    else if (qex < CMIN)  xa_nxt = CMIN[COORD_BITS-1:0];
    else                  xa_nxt = qex[COORD_BITS-1:0];
    if (fault)            ya_nxt = '0;
    else if (qey > CMAX)  ya_nxt = CMAX[COORD_BITS-1:0];
    else if (qey < CMIN)  ya_nxt = CMIN[COORD_BITS-1:0];
    else                  ya_nxt = qey[COORD_BITS-1:0];
  end

  logic signed [DW-1:0] cxe, cye, dx_nxt, dy_nxt, dx_r, dy_r;
  logic signed [COORD_BITS-1:0] xb_r, yb_r, xc_r, yc_r, xd_r, yd_r;
  logic vb_r, bb_r, vc_r, bc_r, vd2_r, bd_r;

  assign cxe    = $signed({{(DW-CTR_W){1'b0}}, cx_r});
  assign cye    = $signed({{(DW-CTR_W){1'b0}}, cy_r});
  assign dx_nxt = DW'(xa_r) - cxe;
  assign dy_nxt = cye - DW'(ya_r);

  logic signed [PW-1:0] pxc_r, pys_r, pyc_r, pxs_r;
  logic signed [SW-1:0] tx_nxt, ty_nxt, tx_r, ty_r;

  assign tx_nxt = SW'(pxc_r) + SW'(pys_r) + SW'(RND_BIAS);
  assign ty_nxt = SW'(pyc_r) - SW'(pxs_r) + SW'(RND_BIAS);

  logic signed [SW-1:0]  qtx, qty;
  logic signed [EXO-1:0] rx, ry, ux, uy;
  logic signed [PIX_W-1:0] px_nxt, py_nxt;
  out_word_t out_r;

  always_comb begin
    qtx = tx_r[SW-1] ? ((tx_r + SW'(32767)) >>> Q15_SH) : (tx_r >>> Q15_SH);
    qty = ty_r[SW-1] ? ((ty_r + SW'(32767)) >>> Q15_SH) : (ty_r >>> Q15_SH);
    ux  = EXO'(xd_r);
    uy  = EXO'(yd_r);
    rx  = skip ? ux : EXO'(cxe) + EXO'(qtx);
    ry  = skip ? uy : EXO'(cye) - EXO'(qty);
    if (rx > PMAX)      px_nxt = PMAX[PIX_W-1:0];
    else if (rx < PMIN) px_nxt = PMIN[PIX_W-1:0];
    else                px_nxt = rx[PIX_W-1:0];
    if (fault)          py_nxt = '0;
    else if (ry > PMAX) py_nxt = PMAX[PIX_W-1:0];
    else if (ry < PMIN) py_nxt = PMIN[PIX_W-1:0];
    else                py_nxt = ry[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
      vd2_r <= 1'b0;
      vo_r  <= 1'b0;
    end else if (adv) begin
      va_r  <= vd_r[NB];
      vb_r  <= va_r;
      vc_r  <= vb_r;
      vd2_r <= vc_r;
      vo_r  <= vd2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xa_r  <= xa_nxt;
      ya_r  <= ya_nxt;
      ba_r  <= ctl_r[NB].batch;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      xb_r  <= xa_r;
      yb_r  <= ya_r;
      bb_r  <= ba_r;
      pxc_r <= PW'(dx_r) * PW'(cos_r);
      pys_r <= PW'(dy_r) * PW'(sin_r);
      pyc_r <= PW'(dy_r) * PW'(cos_r);
      pxs_r <= PW'(dx_r) * PW'(sin_r);
      xc_r  <= xb_r;
      yc_r  <= yb_r;
      bc_r  <= bb_r;
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
      xd_r  <= xc_r;
      yd_r  <= yc_r;
      bd_r  <= bc_r;
      out_r <= '{pixel_x: px_nxt, pixel_y: py_nxt, zoom_fault: fault,
                 batch_end_out: bd_r};
    end
  end

  assign out_valid = vo_r;
  assign out_word  = out_r;

  a_fault_zero_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.zoom_fault |-> out_word.pixel_y == '0)
    else $error("faulted word carries nonzero row");

  a_fault_tracks_zoom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.zoom_fault == fault)
    else $error("fault flag disagrees with vertical zoom");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready not tied to output drain");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_keeps_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(vd_r[NB]))
    else $error("pipeline moved during output stall");

endmodule
